[src/ppi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants for the particle pool integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ONE,
        ST_SPAWN,
        ST_T1_RD,
        ST_T1_SUB,
        ST_T2_RD,
        ST_T2_LOAD,
        ST_T2_VX,
        ST_T2_VY,
        ST_T2_PX,
        ST_T2_PY,
        ST_T2_EMIT
    } state_t;

    // per-slot fields written only at spawn
    typedef struct packed {
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] maxlife;
        logic [DATA_W-2:0]        radius;
        logic [DATA_W-1:0]        color;
        logic [2:0]               kind;
    } stat_t;

    // per-slot fields updated by the integrator
    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
    } dyn_t;

    typedef struct packed {
        logic                     particle_valid;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [DATA_W-2:0]        radius;
        logic [DATA_W-1:0]        rgba;
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] life_left;
        logic signed [DATA_W-1:0] initial_life;
        logic                     spawn_ok;
        logic [CNT_W-1:0]         live_count;
        logic                     last;
    } out_row_t;

endpackage
`default_nettype wire

[src/particle_pool_integrator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_integrator_top
// Pool of particle slots with spawn, semi-implicit Euler tick and clear.
// ----------------------------------------------------------------------------
// One item at a time; in_stall is high until the item's last result is in the
// output register. Clear and the unused op give a single row with the live
// count. Spawn scans the active bits one slot per cycle and is refused when
// the pool is full. Tick runs two passes over the slot RAMs: an aging pass,
// then an integration pass that ends at the last survivor, the four
// multiply-adds going one after another through the single 32x32 multiplier
// and saturating adder.
// ----------------------------------------------------------------------------
module particle_pool_integrator_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          op,
    input  wire logic signed [31:0]                  pos_x,
    input  wire logic signed [31:0]                  pos_y,
    input  wire logic signed [31:0]                  vel_x,
    input  wire logic signed [31:0]                  vel_y,
    input  wire logic signed [31:0]                  acc_x,
    input  wire logic signed [31:0]                  acc_y,
    input  wire logic signed [31:0]                  lifetime,
    input  wire logic [30:0]                         size_radius,
    input  wire logic [31:0]                         rgba,
    input  wire logic [2:0]                          kind,
    input  wire logic [30:0]                         step_time,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     particle_valid,
    output logic [5:0]                               slot,
    output logic signed [31:0]                       out_x,
    output logic signed [31:0]                       out_y,
    output logic [30:0]                              out_radius,
    output logic [31:0]                              out_rgba,
    output logic [2:0]                               out_kind,
    output logic signed [31:0]                       life_left,
    output logic signed [31:0]                       initial_life,
    output logic                                     spawn_ok,
    output logic [6:0]                               live_count,
    output logic                                     last
);

    localparam int SW = ppi_pkg::SLOT_W;
    localparam int CW = ppi_pkg::CNT_W;
    localparam int DW = ppi_pkg::DATA_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(ppi_pkg::SLOT_COUNT - 1);

    ppi_pkg::state_t   state_reg, state_next;
    logic [ppi_pkg::SLOT_COUNT-1:0] active_reg, active_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     emit_reg, emit_next;
    logic [SW-1:0]     idx_reg, idx_next;
    logic              ov_reg, ov_next;
    ppi_pkg::out_row_t row_reg, row_next;

    // latched item payload
    ppi_pkg::stat_t    sp_stat_reg, sp_stat_next;
    ppi_pkg::dyn_t     sp_dyn_reg, sp_dyn_next;
    logic signed [DW-1:0] sp_life_reg, sp_life_next;
    logic [DW-2:0]     dt_reg, dt_next;

    // working values of the slot being integrated
    ppi_pkg::dyn_t     wk_reg, wk_next;

    logic              out_free;

    // RAM ports
    logic              life_we, dyn_we, stat_we;
    logic signed [DW-1:0] life_wdata, life_rdata;
    ppi_pkg::dyn_t     dyn_wdata, dyn_rdata;
    ppi_pkg::stat_t    stat_rdata;

    // ALU ports
    logic signed [DW-1:0] mul_a, mul_b, add_x, add_y, sum;
    logic              use_prod;

    ppi_ram #(.WIDTH(DW), .DEPTH(ppi_pkg::SLOT_COUNT)) u_life_ram (
        .clk   (clk),
        .we    (life_we),
        .waddr (idx_reg),
        .wdata (life_wdata),
        .raddr (idx_reg),
        .rdata (life_rdata)
    );

    ppi_ram #(.WIDTH($bits(ppi_pkg::dyn_t)), .DEPTH(ppi_pkg::SLOT_COUNT)) u_dyn_ram (
        .clk   (clk),
        .we    (dyn_we),
        .waddr (idx_reg),
        .wdata (dyn_wdata),
        .raddr (idx_reg),
        .rdata (dyn_rdata)
    );

    ppi_ram #(.WIDTH($bits(ppi_pkg::stat_t)), .DEPTH(ppi_pkg::SLOT_COUNT)) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (idx_reg),
        .wdata (sp_stat_reg),
        .raddr (idx_reg),
        .rdata (stat_rdata)
    );

    ppi_alu u_alu (
        .clk      (clk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .add_x    (add_x),
        .use_prod (use_prod),
        .add_y    (add_y),
        .sum      (sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ppi_pkg::ST_IDLE;
            active_reg <= '0;
            cnt_reg    <= '0;
            emit_reg   <= '0;
            idx_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            emit_reg   <= emit_next;
            idx_reg    <= idx_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        sp_stat_reg <= sp_stat_next;
        sp_dyn_reg  <= sp_dyn_next;
        sp_life_reg <= sp_life_next;
        dt_reg      <= dt_next;
        wk_reg      <= wk_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        cnt_next     = cnt_reg;
        emit_next    = emit_reg;
        idx_next     = idx_reg;
        sp_stat_next = sp_stat_reg;
        sp_dyn_next  = sp_dyn_reg;
        sp_life_next = sp_life_reg;
        dt_next      = dt_reg;
        wk_next      = wk_reg;
        row_next     = row_reg;
        out_free     = !ov_reg || !out_stall;
        ov_next      = ov_reg && out_stall;

        life_we    = 1'b0;
        dyn_we     = 1'b0;
        stat_we    = 1'b0;
        life_wdata = sp_life_reg;
        dyn_wdata  = sp_dyn_reg;

        mul_a    = stat_rdata.ax;
        mul_b    = {1'b0, dt_reg};
        add_x    = wk_reg.vx;
        add_y    = -{1'b0, dt_reg};
        use_prod = 1'b1;

        case (state_reg)
            ppi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sp_stat_next.ax      = acc_x;
                    sp_stat_next.ay      = acc_y;
                    sp_stat_next.maxlife = lifetime;
                    sp_stat_next.radius  = size_radius;
                    sp_stat_next.color   = rgba;
                    sp_stat_next.kind    = kind;
                    sp_dyn_next.px       = pos_x;
                    sp_dyn_next.py       = pos_y;
                    sp_dyn_next.vx       = vel_x;
                    sp_dyn_next.vy       = vel_y;
                    sp_life_next         = lifetime;
                    dt_next              = step_time;
                    idx_next             = '0;
                    emit_next            = '0;
                    case (ppi_pkg::op_t'(op))
                        ppi_pkg::OP_SPAWN: state_next = ppi_pkg::ST_SPAWN;
                        ppi_pkg::OP_TICK:  state_next = ppi_pkg::ST_T1_RD;
                        ppi_pkg::OP_CLEAR:
                        begin
                            active_next = '0;
                            cnt_next    = '0;
                            state_next  = ppi_pkg::ST_ONE;
                        end
                        default:           state_next = ppi_pkg::ST_ONE;
                    endcase
                end
            end

            ppi_pkg::ST_ONE:
            begin
                if (out_free)
                begin
                    ov_next             = 1'b1;
                    row_next            = '0;
                    row_next.live_count = cnt_reg;
                    row_next.last       = 1'b1;
                    state_next          = ppi_pkg::ST_IDLE;
                end
            end

            ppi_pkg::ST_SPAWN:
            begin
                if (!active_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        life_we              = 1'b1;
                        dyn_we               = 1'b1;
                        stat_we              = 1'b1;
                        active_next[idx_reg] = 1'b1;
                        cnt_next             = CW'(cnt_reg + 1'b1);
                        ov_next              = 1'b1;
                        row_next             = '0;
                        row_next.slot        = idx_reg;
                        row_next.spawn_ok    = 1'b1;
                        row_next.live_count  = CW'(cnt_reg + 1'b1);
                        row_next.last        = 1'b1;
                        state_next           = ppi_pkg::ST_IDLE;
                    end
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    // pool full: refused
                    state_next = ppi_pkg::ST_ONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ppi_pkg::ST_T1_RD:
            begin
                if (active_reg[idx_reg])
                begin
                    state_next = ppi_pkg::ST_T1_SUB;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = ppi_pkg::ST_T2_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ppi_pkg::ST_T1_SUB:
            begin
                add_x      = life_rdata;
                use_prod   = 1'b0;
                life_wdata = sum;
                life_we    = 1'b1;
                if (sum[DW-1] || sum == '0)
                begin
                    active_next[idx_reg] = 1'b0;
                    cnt_next             = CW'(cnt_reg - 1'b1);
                end
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = ppi_pkg::ST_T2_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ppi_pkg::ST_T1_RD;
                end
            end

            ppi_pkg::ST_T2_RD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ppi_pkg::ST_ONE;
                end
                else if (active_reg[idx_reg])
                begin
                    state_next = ppi_pkg::ST_T2_LOAD;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    state_next = ppi_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ppi_pkg::ST_T2_LOAD:
            begin
                // multiply ax*dt while taking the slot's state in
                wk_next    = dyn_rdata;
                mul_a      = stat_rdata.ax;
                state_next = ppi_pkg::ST_T2_VX;
            end

            ppi_pkg::ST_T2_VX:
            begin
                add_x      = wk_reg.vx;
                wk_next.vx = sum;
                mul_a      = stat_rdata.ay;
                state_next = ppi_pkg::ST_T2_VY;
            end

            ppi_pkg::ST_T2_VY:
            begin
                add_x      = wk_reg.vy;
                wk_next.vy = sum;
                mul_a      = wk_reg.vx;
                state_next = ppi_pkg::ST_T2_PX;
            end

            ppi_pkg::ST_T2_PX:
            begin
                add_x      = wk_reg.px;
                wk_next.px = sum;
                mul_a      = wk_reg.vy;
                state_next = ppi_pkg::ST_T2_PY;
            end

            ppi_pkg::ST_T2_PY:
            begin
                add_x      = wk_reg.py;
                wk_next.py = sum;
                state_next = ppi_pkg::ST_T2_EMIT;
            end

            ppi_pkg::ST_T2_EMIT:
            begin
                dyn_wdata = wk_reg;
                if (out_free)
                begin
                    dyn_we                  = 1'b1;
                    ov_next                 = 1'b1;
                    row_next                = '0;
                    row_next.particle_valid = 1'b1;
                    row_next.slot           = idx_reg;
                    row_next.x              = wk_reg.px;
                    row_next.y              = wk_reg.py;
                    row_next.radius         = stat_rdata.radius;
                    row_next.rgba           = stat_rdata.color;
                    row_next.kind           = stat_rdata.kind;
                    row_next.life_left      = life_rdata;
                    row_next.initial_life   = stat_rdata.maxlife;
                    row_next.live_count     = cnt_reg;
                    emit_next               = CW'(emit_reg + 1'b1);
                    // survivors counted in the aging pass tell which row is final
                    if (CW'(emit_reg + 1'b1) == cnt_reg || idx_reg == LAST_SLOT)
                    begin
                        row_next.last = 1'b1;
                        state_next    = ppi_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ppi_pkg::ST_T2_RD;
                    end
                end
            end

            default:
            begin
                state_next = ppi_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall       = (state_reg != ppi_pkg::ST_IDLE);
    assign out_valid      = ov_reg;
    assign particle_valid = row_reg.particle_valid;
    assign slot           = row_reg.slot;
    assign out_x          = row_reg.x;
    assign out_y          = row_reg.y;
    assign out_radius     = row_reg.radius;
    assign out_rgba       = row_reg.rgba;
    assign out_kind       = row_reg.kind;
    assign life_left      = row_reg.life_left;
    assign initial_life   = row_reg.initial_life;
    assign spawn_ok       = row_reg.spawn_ok;
    assign live_count     = row_reg.live_count;
    assign last           = row_reg.last;

    a_cnt_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_reg) == cnt_reg)
        else $error("live count disagrees with active bits");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ppi_pkg::SLOT_COUNT))
        else $error("live count above pool size");

    a_survivor_not_spawn: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && row_reg.particle_valid) |-> !row_reg.spawn_ok)
        else $error("survivor row flagged as spawn");

    a_row_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(row_reg)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

[src/ppi_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/ppi_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_alu
// Shared multiplier (registered product) and saturating 32-bit adder.
// ----------------------------------------------------------------------------
module ppi_alu (
    input  wire logic                                clk,
    input  wire logic signed [ppi_pkg::DATA_W-1:0]   mul_a,
    input  wire logic signed [ppi_pkg::DATA_W-1:0]   mul_b,
    input  wire logic signed [ppi_pkg::DATA_W-1:0]   add_x,
    input  wire logic                                use_prod,
    input  wire logic signed [ppi_pkg::DATA_W-1:0]   add_y,
    output logic signed [ppi_pkg::DATA_W-1:0]        sum
);

    localparam int PW    = 2 * ppi_pkg::DATA_W;
    localparam int SUM_W = PW - ppi_pkg::FRAC_BITS + 1;

    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    prod_sh;
    logic signed [SUM_W-1:0] y_ext;
    logic signed [SUM_W-1:0] s;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        // arithmetic shift drops fraction bits, rounding toward minus infinity
        prod_sh = prod_reg >>> ppi_pkg::FRAC_BITS;
        y_ext   = use_prod ? prod_sh[SUM_W-1:0] : SUM_W'(add_y);
        s       = SUM_W'(add_x) + y_ext;
        if (s[SUM_W-1:ppi_pkg::DATA_W-1] == '0 || s[SUM_W-1:ppi_pkg::DATA_W-1] == '1)
        begin
            sum = s[ppi_pkg::DATA_W-1:0];
        end
        else if (s[SUM_W-1])
        begin
            sum = {1'b1, {(ppi_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            sum = {1'b0, {(ppi_pkg::DATA_W-1){1'b1}}};
        end
    end

endmodule
`default_nettype wire
